FILE: rtl/core/lzrc_pkg.sv
// ----------------------------------------------------------------------------
// lzrc_pkg
// Shared types and codes of the run/copy LZ decompressor.
// ----------------------------------------------------------------------------
package lzrc_pkg;

  localparam logic [1:0] FN_PUSH    = 2'd0;
  localparam logic [1:0] FN_PULL    = 2'd1;
  localparam logic [1:0] FN_RESTART = 2'd2;

  localparam logic [2:0] ST_ACCEPT  = 3'd0;
  localparam logic [2:0] ST_PRODUCE = 3'd1;
  localparam logic [2:0] ST_NEED    = 3'd2;
  localparam logic [2:0] ST_REFUSE  = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  localparam logic [2:0] CM_LITERAL  = 3'd0;
  localparam logic [2:0] CM_REPEAT   = 3'd1;
  localparam logic [2:0] CM_ALTERNATE = 3'd2;
  localparam logic [2:0] CM_ZERO     = 3'd3;
  localparam logic [2:0] CM_COPY     = 3'd4;
  localparam logic [2:0] CM_MIRBITS  = 3'd5;
  localparam logic [2:0] CM_MIRBYTES = 3'd6;
  localparam logic [2:0] CM_NONE     = 3'd7;

  localparam logic [7:0] END_MARK  = 8'hFF;
  localparam logic [2:0] LONG_MARK = 3'd7;

  typedef enum logic [6:0] {
    PH_CMD    = 7'b0000001,
    PH_LONG   = 7'b0000010,
    PH_ARG1   = 7'b0000100,
    PH_ARG2   = 7'b0001000,
    PH_LIT    = 7'b0010000,
    PH_LITRDY = 7'b0100000,
    PH_RUN    = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] in_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       out_last;
  } result_t;

  typedef struct packed {
    logic        finished;
    logic [12:0] write_count;
  } back_stat_t;

endpackage

FILE: rtl/core/lzrc_in_if.sv
// ----------------------------------------------------------------------------
// lzrc_in_if
// Input channel: func and compressed byte with valid/ready.
// ----------------------------------------------------------------------------
interface lzrc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] in_byte;
  modport source(output valid, func, in_byte, input ready);
  modport sink(input valid, func, in_byte, output ready);
endinterface

FILE: rtl/core/lzrc_out_if.sv
// ----------------------------------------------------------------------------
// lzrc_out_if
// Result channel: produced byte, status and last flag with valid/ready.
// ----------------------------------------------------------------------------
interface lzrc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       out_last;
  modport source(output valid, out_byte, status, out_last, input ready);
  modport sink(input valid, out_byte, status, out_last, output ready);
endinterface

FILE: rtl/core/lzrc_front.sv
// ----------------------------------------------------------------------------
// lzrc_front
// Two-entry word queue between the input channel and the execution stage.
// ----------------------------------------------------------------------------
module lzrc_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lzrc_pkg::item_t push_item,
  output logic           can_push,
  input  logic           pop,
  output logic           head_valid,
  output lzrc_pkg::item_t head_item
);

  lzrc_pkg::item_t ent_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign can_push   = (cnt_r != 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = ent_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wptr_r] <= push_item;
  end

endmodule

FILE: rtl/core/lzrc_back.sv
// ----------------------------------------------------------------------------
// lzrc_back
// Execution stage: parse state, history memory and one result per word.
// ----------------------------------------------------------------------------
module lzrc_back #(
  parameter int HISTORY_DEPTH = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  lzrc_pkg::item_t     item,
  input  logic [12:0]         out_limit,
  output lzrc_pkg::result_t   result,
  output lzrc_pkg::back_stat_t stat
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [16:0] DEPTH_EXT = 17'(HISTORY_DEPTH);

  lzrc_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [10:0] rem_r, rem_nxt;
  logic [7:0]  fa_r, fa_nxt, fb_r, fb_nxt;
  logic        odd_r, odd_nxt;
  logic [16:0] rp_r, rp_nxt;
  logic [12:0] wc_r, wc_nxt;
  logic        fin_r, fin_nxt;

  logic [7:0]  hist_mem [HISTORY_DEPTH];
  logic [7:0]  rd_r;
  logic        we;
  logic [7:0]  wdata;
  logic [16:0] wc_ext, lim_ext, eff_lim;
  logic        hist_ok;
  logic [7:0]  hist_val;
  logic        emit_en;
  logic [7:0]  emit_val;
  logic [7:0]  b;

  function automatic lzrc_pkg::phase_t start_phase(input logic [2:0] c);
    lzrc_pkg::phase_t p;
    case (c)
      lzrc_pkg::CM_LITERAL: p = lzrc_pkg::PH_LIT;
      lzrc_pkg::CM_ZERO:    p = lzrc_pkg::PH_RUN;
      lzrc_pkg::CM_NONE:    p = lzrc_pkg::PH_CMD;
      default:              p = lzrc_pkg::PH_ARG1;
    endcase
    return p;
  endfunction

  assign b       = item.in_byte;
  assign wc_ext  = {4'b0, wc_r};
  assign lim_ext = {4'b0, out_limit};
  assign eff_lim = (out_limit == 13'd0) ? 17'd1 :
                   ((lim_ext > DEPTH_EXT) ? DEPTH_EXT : lim_ext);
  // out-of-history reads yield zero
  assign hist_ok  = !rp_r[16] && (rp_r < wc_ext) && (rp_r < DEPTH_EXT);
  assign hist_val = hist_ok ? rd_r : 8'd0;
  assign stat     = '{finished: fin_r, write_count: wc_r};

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    rem_nxt   = rem_r;
    fa_nxt    = fa_r;
    fb_nxt    = fb_r;
    odd_nxt   = odd_r;
    rp_nxt    = rp_r;
    wc_nxt    = wc_r;
    fin_nxt   = fin_r;
    result    = '0;
    emit_en   = 1'b0;
    emit_val  = 8'd0;
    we        = 1'b0;
    wdata     = 8'd0;
    if (step) begin
      if (item.func == lzrc_pkg::FN_RESTART) begin
        phase_nxt = lzrc_pkg::PH_CMD;
        cmd_nxt   = 3'd0;
        rem_nxt   = 11'd0;
        fa_nxt    = 8'd0;
        fb_nxt    = 8'd0;
        odd_nxt   = 1'b0;
        rp_nxt    = 17'd0;
        wc_nxt    = 13'd0;
        fin_nxt   = 1'b0;
        result.status = lzrc_pkg::ST_ACCEPT;
      end else if (item.func != lzrc_pkg::FN_PUSH && item.func != lzrc_pkg::FN_PULL) begin
        result.status = lzrc_pkg::ST_ACCEPT;
      end else if (fin_r) begin
        result.status = lzrc_pkg::ST_DONE;
      end else if (item.func == lzrc_pkg::FN_PUSH) begin
        result.status = lzrc_pkg::ST_ACCEPT;
        case (phase_r)
          lzrc_pkg::PH_CMD: begin
            if (b == lzrc_pkg::END_MARK) begin
              fin_nxt = 1'b1;
            end else if (b[7:5] == lzrc_pkg::LONG_MARK) begin
              cmd_nxt   = b[4:2];
              rem_nxt   = {1'b0, b[1:0], 8'd0};
              phase_nxt = lzrc_pkg::PH_LONG;
            end else begin
              cmd_nxt   = b[7:5];
              rem_nxt   = {6'd0, b[4:0]} + 11'd1;
              phase_nxt = start_phase(b[7:5]);
              odd_nxt   = 1'b0;
            end
          end
          lzrc_pkg::PH_LONG: begin
            rem_nxt   = rem_r + {3'd0, b} + 11'd1;
            phase_nxt = start_phase(cmd_r);
            odd_nxt   = 1'b0;
          end
          lzrc_pkg::PH_ARG1: begin
            if (cmd_r == lzrc_pkg::CM_REPEAT) begin
              fa_nxt    = b;
              phase_nxt = lzrc_pkg::PH_RUN;
            end else if (cmd_r == lzrc_pkg::CM_ALTERNATE) begin
              fa_nxt    = b;
              phase_nxt = lzrc_pkg::PH_ARG2;
            end else if (b[7]) begin
              rp_nxt    = wc_ext - {10'd0, b[6:0]} - 17'd1;
              phase_nxt = lzrc_pkg::PH_RUN;
            end else begin
              rp_nxt    = {1'b0, b, 8'd0};
              phase_nxt = lzrc_pkg::PH_ARG2;
            end
          end
          lzrc_pkg::PH_ARG2: begin
            if (cmd_r == lzrc_pkg::CM_ALTERNATE) fb_nxt = b;
            else rp_nxt = rp_r + {9'd0, b};
            phase_nxt = lzrc_pkg::PH_RUN;
          end
          lzrc_pkg::PH_LIT: begin
            fa_nxt    = b;
            phase_nxt = lzrc_pkg::PH_LITRDY;
          end
          default: result.status = lzrc_pkg::ST_REFUSE;
        endcase
      end else if (phase_r == lzrc_pkg::PH_LITRDY) begin
        emit_en  = 1'b1;
        emit_val = fa_r;
      end else if (phase_r == lzrc_pkg::PH_RUN) begin
        emit_en = 1'b1;
        case (cmd_r)
          lzrc_pkg::CM_REPEAT: emit_val = fa_r;
          lzrc_pkg::CM_ALTERNATE: begin
            emit_val = odd_r ? fb_r : fa_r;
            odd_nxt  = ~odd_r;
          end
          lzrc_pkg::CM_COPY: begin
            emit_val = hist_val;
            rp_nxt   = rp_r + 17'd1;
          end
          lzrc_pkg::CM_MIRBITS: begin
            emit_val = {<<{hist_val}};
            rp_nxt   = rp_r + 17'd1;
          end
          lzrc_pkg::CM_MIRBYTES: begin
            emit_val = hist_val;
            rp_nxt   = rp_r - 17'd1;
          end
          default: emit_val = 8'd0;
        endcase
      end else begin
        result.status = lzrc_pkg::ST_NEED;
      end

      if (emit_en) begin
        result.status   = lzrc_pkg::ST_PRODUCE;
        result.out_byte = emit_val;
        we      = (wc_ext < DEPTH_EXT);
        wdata   = emit_val;
        wc_nxt  = wc_r + 13'd1;
        rem_nxt = rem_r - 11'd1;
        if ({4'b0, wc_nxt} >= eff_lim) begin
          fin_nxt         = 1'b1;
          result.out_last = 1'b1;
        end else if (rem_nxt == 11'd0) begin
          phase_nxt = lzrc_pkg::PH_CMD;
        end else if (phase_r == lzrc_pkg::PH_LITRDY) begin
          phase_nxt = lzrc_pkg::PH_LIT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lzrc_pkg::PH_CMD;
      cmd_r   <= 3'd0;
      rem_r   <= 11'd0;
      fa_r    <= 8'd0;
      fb_r    <= 8'd0;
      odd_r   <= 1'b0;
      rp_r    <= 17'd0;
      wc_r    <= 13'd0;
      fin_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      rem_r   <= rem_nxt;
      fa_r    <= fa_nxt;
      fb_r    <= fb_nxt;
      odd_r   <= odd_nxt;
      rp_r    <= rp_nxt;
      wc_r    <= wc_nxt;
      fin_r   <= fin_nxt;
    end
  end

  // prefetch the word at the next read pointer; forward a same-cycle write
  always_ff @(posedge clk) begin
    if (we) hist_mem[wc_ext[AW-1:0]] <= wdata;
    if (we && (wc_ext[AW-1:0] == rp_nxt[AW-1:0])) rd_r <= wdata;
    else rd_r <= hist_mem[rp_nxt[AW-1:0]];
  end

endmodule

FILE: rtl/core/lz_run_copy_decompressor.sv
// ----------------------------------------------------------------------------
// lz_run_copy_decompressor
// Streaming run/copy LZ decompressor with push/pull/restart words.
//
//   channel  | dir | handshake           | payload
//   in_ch    | in  | valid/ready         | func, in_byte
//   out_ch   | out | valid/ready         | out_byte, status, out_last
//   cfg      | in  | APB psel/penable    | out_limit at byte address 0
//
// One word per cycle while out_ch is ready; the result is registered.
// The history memory has one write and one registered read port; the read
// is prefetched at the next read pointer, so copies run at full rate.
// rst_n is synchronous; no memory clearing pass is needed.
// A stalled result holds in the output register; the queue absorbs two words.
// ----------------------------------------------------------------------------
module lz_run_copy_decompressor #(
  parameter int HISTORY_DEPTH = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  lzrc_in_if.sink      in_ch,
  lzrc_out_if.source   out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [12:0] out_limit_r;
  logic        in_push, can_push, head_valid, step;
  lzrc_pkg::item_t      in_item, head_item;
  lzrc_pkg::result_t    res, res_r;
  lzrc_pkg::back_stat_t stat;
  logic        out_valid_r;

  assign pready = 1'b1;
  assign prdata = {19'd0, out_limit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_limit_r <= 13'd576;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      out_limit_r <= pwdata[12:0];
    end
  end

  assign in_item  = '{func: in_ch.func, in_byte: in_ch.in_byte};
  assign in_ch.ready = can_push;
  assign in_push  = in_ch.valid && can_push;
  assign step     = head_valid && (!out_valid_r || out_ch.ready);

  lzrc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_item (in_item),
    .can_push  (can_push),
    .pop       (step),
    .head_valid(head_valid),
    .head_item (head_item)
  );

  lzrc_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .item     (head_item),
    .out_limit(out_limit_r),
    .result   (res),
    .stat     (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res_r <= res;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = res_r.out_byte;
  assign out_ch.status   = res_r.status;
  assign out_ch.out_last = res_r.out_last;

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && head_item.func == lzrc_pkg::FN_RESTART |=>
      stat.write_count == 13'd0 && !stat.finished)
    else $error("restart did not clear stream state");

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("executed word left no result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {4'b0, stat.write_count} <= 17'(HISTORY_DEPTH))
    else $error("write count beyond history depth");

endmodule
